// ----- rtl/datnd_pkg.sv -----
// Shared types and constants for the daily alarm table with next-due search.
package datnd_pkg;

  localparam int unsigned ENTRY_W = 21;

  localparam logic [10:0] DAY_MINUTES  = 11'd1440;
  localparam logic [10:0] HOUR_MINUTES = 11'd60;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_UPDATE = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_QUERY  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_DUP_TIME = 2'd1,
    STS_FULL     = 2'd2,
    STS_BAD_SLOT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DUP,
    ST_EXEC,
    ST_SHIFT,
    ST_SRCH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [9:0] portion;
  } alarm_t;

endpackage

// ----- rtl/datnd_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
module datnd_ram #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/daily_alarm_table_next_due_top.sv -----
// Top level of the daily alarm table with next-due search.
//
// Holds up to MAX_ENTRIES daily alarms (hour, minute, portion) packed in slot
// order in one RAM with a registered read. An item is taken when start is
// high and busy is low; busy then stays high until the result has been
// shown. The result appears on the result ports for exactly one cycle,
// flagged by done_o, and must be taken then: there is no back-pressure.
// Each item runs through a sequencer that walks the RAM one entry per cycle.
// A pass issues one read per entry, waits for the last read data and then
// closes; a pass with nothing to read only closes. The steps are: a
// duplicate-time scan (insert and update only), a state to check and write,
// a shift-down pass on a delete of a stored slot, a next-due search over the
// resulting table and a result state. Busy drops for one idle cycle before
// the next item can be taken. No clearing pass is needed after reset: only
// slots below the entry count are ever read.
module daily_alarm_table_next_due_top #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  slot_i,
  input  logic [4:0]  alarm_hour_i,
  input  logic [5:0]  alarm_minute_i,
  input  logic [9:0]  portion_i,
  input  logic [10:0] now_minute_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic        next_valid_o,
  output logic [3:0]  next_slot_o,
  output logic [4:0]  next_hour_o,
  output logic [5:0]  next_minute_o,
  output logic [9:0]  next_portion_o,
  output logic [10:0] wait_minutes_o,
  output logic [4:0]  entry_count_o
);

  import datnd_pkg::*;

  // AW indexes the RAM, CW holds a count up to MAX_ENTRIES itself.
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SW = (CW > 4) ? CW : 4;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;     // next entry to read
  logic            pv_q;             // read data valid this cycle
  logic [AW-1:0]   pidx_q;           // entry that the read data belongs to
  logic            dup_q, dup_d;
  logic            found_q, found_d;

  req_e            req_q;
  logic [3:0]      slot_q;
  alarm_t          alarm_q;
  logic [10:0]     now_q;
  status_e         status_q;
  logic [10:0]     best_wait_q;
  logic [AW-1:0]   best_slot_q;
  alarm_t          best_data_q;

  logic            accept;
  logic            issue;
  logic            pass_end;
  logic            slot_ok;
  logic            full;
  logic            ins_ok, upd_ok, del_ok;
  status_e         exec_status;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  alarm_t          ram_wdata;
  alarm_t          ram_rdata;

  logic [10:0]     at_min;
  logic [11:0]     wrap_wait;
  logic [10:0]     cand_wait;
  logic            take_cand;

  datnd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // A pass walks entries idx_q..count_q-1; it ends once the last read is back.
  assign issue    = (state_q inside {ST_DUP, ST_SHIFT, ST_SRCH}) && (idx_q != count_q);
  assign pass_end = (idx_q == count_q) && !pv_q;

  // Request checks, in the order duplicate, then full or bad slot.
  assign slot_ok = (SW'(slot_q) < SW'(count_q));
  assign full    = (count_q == CW'(MAX_ENTRIES));
  assign ins_ok  = (req_q == REQ_INSERT) && !dup_q && !full;
  assign upd_ok  = (req_q == REQ_UPDATE) && !dup_q && slot_ok;
  assign del_ok  = (req_q == REQ_DELETE) && slot_ok;

  always_comb begin
    exec_status = STS_OK;
    case (req_q)
      REQ_INSERT: begin
        if (dup_q) begin
          exec_status = STS_DUP_TIME;
        end else if (full) begin
          exec_status = STS_FULL;
        end
      end
      REQ_UPDATE: begin
        if (dup_q) begin
          exec_status = STS_DUP_TIME;
        end else if (!slot_ok) begin
          exec_status = STS_BAD_SLOT;
        end
      end
      REQ_DELETE: begin
        if (!slot_ok) begin
          exec_status = STS_BAD_SLOT;
        end
      end
      default: begin
        exec_status = STS_OK;
      end
    endcase
  end

  // Wait from now to an entry; zero or less wraps by a day.
  assign at_min    = 11'(ram_rdata.hour) * HOUR_MINUTES + 11'(ram_rdata.minute);
  assign wrap_wait = 12'(at_min) + 12'(DAY_MINUTES) - 12'(now_q);
  assign cand_wait = (at_min > now_q) ? (at_min - now_q) : wrap_wait[10:0];
  assign take_cand = !found_q || (cand_wait <= best_wait_q);  // later slot wins a tie

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if ((req_type_i == REQ_INSERT) || (req_type_i == REQ_UPDATE)) begin
            state_d = ST_DUP;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_DUP: begin
        if (pass_end) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = del_ok ? ST_SHIFT : ST_SRCH;
      end
      ST_SHIFT: begin
        if (pass_end) begin
          state_d = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (pass_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[AW-1:0];
    ram_wdata = alarm_q;
    idx_d     = idx_q;
    count_d   = count_q;
    dup_d     = dup_q;
    found_d   = found_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          idx_d = '0;
          dup_d = 1'b0;
        end
      end
      ST_DUP: begin
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end
        if (pv_q && (ram_rdata.hour == alarm_q.hour) &&
            (ram_rdata.minute == alarm_q.minute)) begin
          dup_d = 1'b1;
        end
      end
      ST_EXEC: begin
        found_d = 1'b0;
        idx_d   = del_ok ? (CW'(slot_q) + CW'(1)) : '0;
        if (ins_ok) begin
          ram_we  = 1'b1;
          count_d = count_q + CW'(1);
        end else if (upd_ok) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(slot_q);
        end
      end
      ST_SHIFT: begin
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end
        if (pv_q) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_q - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (pass_end) begin
          idx_d   = '0;
          count_d = count_q - CW'(1);
        end
      end
      ST_SRCH: begin
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end
        if (pv_q) begin
          found_d = 1'b1;
        end
      end
      default: begin
        idx_d = idx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      pv_q    <= 1'b0;
      dup_q   <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      pv_q    <= issue;
      dup_q   <= dup_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= idx_q[AW-1:0];
    if (accept) begin
      req_q          <= req_e'(req_type_i);
      slot_q         <= slot_i;
      alarm_q.hour    <= alarm_hour_i;
      alarm_q.minute  <= alarm_minute_i;
      alarm_q.portion <= portion_i;
      now_q          <= (now_minute_i >= DAY_MINUTES) ? (now_minute_i - DAY_MINUTES)
                                                      : now_minute_i;
    end
    if (state_q == ST_EXEC) begin
      status_q <= exec_status;
    end
    if ((state_q == ST_SRCH) && pv_q && take_cand) begin
      best_wait_q <= cand_wait;
      best_slot_q <= pidx_q;
      best_data_q <= ram_rdata;
    end
  end

  // Result, shown for the single cycle in ST_DONE
  assign done_o         = (state_q == ST_DONE);
  assign status_o       = status_q;
  assign next_valid_o   = found_q;
  assign next_slot_o    = found_q ? 4'(best_slot_q) : 4'd0;
  assign next_hour_o    = found_q ? best_data_q.hour : 5'd0;
  assign next_minute_o  = found_q ? best_data_q.minute : 6'd0;
  assign next_portion_o = found_q ? best_data_q.portion : 10'd0;
  assign wait_minutes_o = found_q ? best_wait_q : 11'd0;
  assign entry_count_o  = 5'(count_q);

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == ST_EXEC) || (state_q == ST_SHIFT)))
    else $error("table write outside exec or shift");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CW'(ram_waddr) < count_d))
    else $error("table write beyond stored entries");

  a_done_after_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == ST_SRCH))
    else $error("result without a search pass");

  a_found_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (found_q == (count_q != '0)))
    else $error("next-due flag disagrees with entry count");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the daily alarm table with next-due search.
module tb_top;
  import datnd_pkg::*;

  // Shadow table depth matches the block's default MAX_ENTRIES.
  localparam int unsigned TABLE_DEPTH  = 16;
  // Settle time after the last report.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned DRAIN_LIMIT   = 2000;
  localparam int unsigned REPORT_LIMIT  = 10;

  // One next-due report, laid out as the result ports.
  typedef struct packed {
    status_e     status;
    logic        next_valid;
    logic [3:0]  next_slot;
    logic [4:0]  next_hour;
    logic [5:0]  next_minute;
    logic [9:0]  next_portion;
    logic [10:0] wait_minutes;
    logic [4:0]  entry_count;
  } due_report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  req_type_i;
  logic [3:0]  slot_i;
  logic [4:0]  alarm_hour_i;
  logic [5:0]  alarm_minute_i;
  logic [9:0]  portion_i;
  logic [10:0] now_minute_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic        next_valid_o;
  logic [3:0]  next_slot_o;
  logic [4:0]  next_hour_o;
  logic [5:0]  next_minute_o;
  logic [9:0]  next_portion_o;
  logic [10:0] wait_minutes_o;
  logic [4:0]  entry_count_o;

  // Shadow copy of the alarm table; only entries below shadow_count are meaningful.
  alarm_t      shadow_alarms [TABLE_DEPTH];
  int unsigned shadow_count;

  // Reports still owed by the block, oldest first.
  due_report_t due_reports_q [$];
  int unsigned mismatch_count;
  // Cleared for some phases so that items go back to back.
  bit          gaps_on;

  daily_alarm_table_next_due_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .slot_i         (slot_i),
    .alarm_hour_i   (alarm_hour_i),
    .alarm_minute_i (alarm_minute_i),
    .portion_i      (portion_i),
    .now_minute_i   (now_minute_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .next_valid_o   (next_valid_o),
    .next_slot_o    (next_slot_o),
    .next_hour_o    (next_hour_o),
    .next_minute_o  (next_minute_o),
    .next_portion_o (next_portion_o),
    .wait_minutes_o (wait_minutes_o),
    .entry_count_o  (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Applies one request to the shadow table and works out the report it owes.
  // Duplicate time is checked before full or bad slot; a refused request
  // leaves the table alone but still gets a search.
  function automatic due_report_t apply_request(req_e req, logic [3:0] slot,
      logic [4:0] hour, logic [5:0] minute, logic [9:0] portion, logic [10:0] now);
    due_report_t rep;
    bit          taken;
    bit          found;
    int unsigned i;
    int unsigned now_m;
    int unsigned at_m;
    int unsigned wait_m;
    int unsigned best_wait;
    int unsigned best_slot;
    rep        = '0;
    rep.status = STS_OK;
    taken      = 1'b0;
    for (i = 0; i < shadow_count; i++)
      if (shadow_alarms[i].hour == hour && shadow_alarms[i].minute == minute) taken = 1'b1;

    case (req)
      REQ_INSERT: begin
        if (taken) rep.status = STS_DUP_TIME;
        else if (shadow_count >= TABLE_DEPTH) rep.status = STS_FULL;
        else begin
          shadow_alarms[shadow_count] = '{hour: hour, minute: minute, portion: portion};
          shadow_count++;
        end
      end
      REQ_UPDATE: begin
        if (taken) rep.status = STS_DUP_TIME;
        else if (slot >= shadow_count) rep.status = STS_BAD_SLOT;
        else shadow_alarms[slot] = '{hour: hour, minute: minute, portion: portion};
      end
      REQ_DELETE: begin
        if (slot >= shadow_count) rep.status = STS_BAD_SLOT;
        else begin
          for (i = slot; i + 1 < shadow_count; i++) shadow_alarms[i] = shadow_alarms[i + 1];
          shadow_count--;
        end
      end
      default: ;
    endcase

    // Out-of-range current minute folds back into the day once.
    now_m = now;
    if (now_m >= DAY_MINUTES) now_m -= DAY_MINUTES;

    // Smallest wait wins; <= lets the later slot take a tie. Zero or less wraps.
    found     = 1'b0;
    best_wait = 0;
    best_slot = 0;
    for (i = 0; i < shadow_count; i++) begin
      at_m   = shadow_alarms[i].hour * HOUR_MINUTES + shadow_alarms[i].minute;
      wait_m = (at_m > now_m) ? at_m - now_m : at_m + DAY_MINUTES - now_m;
      if (!found || wait_m <= best_wait) begin
        found     = 1'b1;
        best_wait = wait_m;
        best_slot = i;
      end
    end

    rep.entry_count = shadow_count[4:0];
    if (found) begin
      rep.next_valid   = 1'b1;
      rep.next_slot    = best_slot[3:0];
      rep.next_hour    = shadow_alarms[best_slot].hour;
      rep.next_minute  = shadow_alarms[best_slot].minute;
      rep.next_portion = shadow_alarms[best_slot].portion;
      rep.wait_minutes = best_wait[10:0];
    end
    return rep;
  endfunction

  // Sends one item: optional idle gap, then hold start until busy is low at an
  // edge. Start is left high afterwards so a back-to-back item needs no
  // low-then-high in one step; whoever comes next lowers it if needed.
  task automatic send_request(req_e req, logic [3:0] slot, logic [4:0] hour,
      logic [5:0] minute, logic [9:0] portion, logic [10:0] now);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(6, 0) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    req_type_i     <= req;
    slot_i         <= slot;
    alarm_hour_i   <= hour;
    alarm_minute_i <= minute;
    portion_i      <= portion;
    now_minute_i   <= now;
    do @(posedge clk_i); while (busy);
    due_reports_q.push_back(apply_request(req, slot, hour, minute, portion, now));
  endtask

  // Sender holds off until every owed report has come back.
  task automatic wait_drained();
    start <= 1'b0;
    while (due_reports_q.size() != 0) @(posedge clk_i);
  endtask

  // Checker: every done_o strobe is one report, compared against the oldest owed.
  always @(posedge clk_i) begin
    due_report_t got;
    due_report_t want;
    if (rst_ni && done_o) begin
      got.status       = status_e'(status_o);
      got.next_valid   = next_valid_o;
      got.next_slot    = next_slot_o;
      got.next_hour    = next_hour_o;
      got.next_minute  = next_minute_o;
      got.next_portion = next_portion_o;
      got.wait_minutes = wait_minutes_o;
      got.entry_count  = entry_count_o;
      if (due_reports_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: report with none owed: sts=%0d v=%0d slot=%0d %0d:%0d p=%0d w=%0d n=%0d",
                   $realtime, got.status, got.next_valid, got.next_slot, got.next_hour,
                   got.next_minute, got.next_portion, got.wait_minutes, got.entry_count);
      end else begin
        want = due_reports_q.pop_front();
        if (got.status !== want.status || got.next_valid !== want.next_valid ||
            got.next_slot !== want.next_slot || got.next_hour !== want.next_hour ||
            got.next_minute !== want.next_minute || got.next_portion !== want.next_portion ||
            got.wait_minutes !== want.wait_minutes || got.entry_count !== want.entry_count) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: report mismatch", $realtime);
            $display("  want sts=%0d v=%0d slot=%0d %0d:%0d p=%0d w=%0d n=%0d",
                     want.status, want.next_valid, want.next_slot, want.next_hour,
                     want.next_minute, want.next_portion, want.wait_minutes, want.entry_count);
            $display("  got  sts=%0d v=%0d slot=%0d %0d:%0d p=%0d w=%0d n=%0d",
                     got.status, got.next_valid, got.next_slot, got.next_hour,
                     got.next_minute, got.next_portion, got.wait_minutes, got.entry_count);
          end
        end
      end
    end
  end

  // Empty table: all next-due fields zero, bad slot on delete and update,
  // and an out-of-range current minute.
  task automatic test_empty_table();
    send_request(REQ_QUERY,  4'd0,  5'd0, 6'd0, 10'd0, 11'd0);
    send_request(REQ_QUERY,  4'd15, 5'd0, 6'd0, 10'd0, 11'd2047);
    send_request(REQ_DELETE, 4'd0,  5'd0, 6'd0, 10'd0, 11'd100);
    send_request(REQ_UPDATE, 4'd15, 5'd5, 6'd5, 10'd7, 11'd100);
  endtask

  // Insert and update against duplicate times, own slot included, and the
  // order of the duplicate and bad-slot checks.
  task automatic test_duplicates();
    send_request(REQ_INSERT, 4'd0, 5'd0,  6'd0,  10'd0,    11'd0);    // zero diff wraps to 1440
    send_request(REQ_INSERT, 4'd0, 5'd23, 6'd59, 10'd1000, 11'd1440); // now folds to 0
    send_request(REQ_INSERT, 4'd0, 5'd0,  6'd0,  10'd3,    11'd10);
    send_request(REQ_UPDATE, 4'd1, 5'd0,  6'd0,  10'd3,    11'd10);   // clashes with other slot
    send_request(REQ_UPDATE, 4'd1, 5'd23, 6'd59, 10'd3,    11'd10);   // clashes with own slot
    send_request(REQ_UPDATE, 4'd7, 5'd12, 6'd0,  10'd3,    11'd10);   // beyond count
    send_request(REQ_UPDATE, 4'd7, 5'd23, 6'd59, 10'd3,    11'd10);   // duplicate reported first
    send_request(REQ_UPDATE, 4'd0, 5'd6,  6'd30, 10'd512,  11'd390);
  endtask

  // Hour and minute beyond their ranges, full-width portion, and two entries at the same minute of day.
  task automatic test_out_of_range_and_ties();
    send_request(REQ_INSERT, 4'd0, 5'd31, 6'd63, 10'd1023, 11'd0);    // 1923 minutes away
    send_request(REQ_INSERT, 4'd0, 5'd1,  6'd0,  10'd11,   11'd30);
    send_request(REQ_INSERT, 4'd0, 5'd0,  6'd60, 10'd22,   11'd30);   // same minute of day
    send_request(REQ_QUERY,  4'd0, 5'd0,  6'd0,  10'd0,    11'd60);   // both wrap to 1440, but slot 0 at 6:30 is nearer
  endtask

  // Fill the table, then a full insert and a duplicate on a full table.
  task automatic test_full_table();
    logic [4:0] hour;
    hour = 5'd2;
    while (shadow_count < TABLE_DEPTH) begin
      send_request(REQ_INSERT, 4'd0, hour, 6'd17, 10'($urandom_range(1000, 0)),
                   11'($urandom_range(1439, 0)));
      hour++;
    end
    send_request(REQ_INSERT, 4'd0,  5'd22, 6'd17, 10'd5, 11'd700);
    send_request(REQ_INSERT, 4'd0,  5'd23, 6'd59, 10'd5, 11'd700);
    send_request(REQ_UPDATE, 4'd15, 5'd22, 6'd18, 10'd6, 11'd1439);
  endtask

  // Delete with shifting at the front, the last slot, and a slot just gone.
  task automatic test_delete_shift();
    send_request(REQ_DELETE, 4'd0,  5'd0, 6'd0, 10'd0, 11'd500);
    send_request(REQ_DELETE, 4'd14, 5'd0, 6'd0, 10'd0, 11'd500);
    send_request(REQ_DELETE, 4'd14, 5'd0, 6'd0, 10'd0, 11'd500);
    send_request(REQ_DELETE, 4'd5,  5'd0, 6'd0, 10'd0, 11'd1000);
  endtask

  // Alarm time: mostly in range, sometimes a stored time to provoke
  // duplicates, sometimes any value the port allows.
  task automatic pick_time(output logic [4:0] hour, output logic [5:0] minute);
    int unsigned k;
    int unsigned idx;
    k = $urandom_range(15, 0);
    if (k < 4 && shadow_count != 0) begin
      idx    = $urandom_range(shadow_count - 1, 0);
      hour   = shadow_alarms[idx].hour;
      minute = shadow_alarms[idx].minute;
    end else if (k == 4) begin
      hour   = 5'($urandom_range(31, 0));
      minute = 6'($urandom_range(63, 0));
    end else begin
      hour   = 5'($urandom_range(23, 0));
      minute = 6'($urandom_range(59, 0));
    end
  endtask

  // Random requests; the weights steer the table towards full or empty.
  task automatic test_random_mix(int unsigned count, int unsigned insert_wt,
      int unsigned delete_wt);
    int unsigned n;
    int unsigned r;
    int unsigned idx;
    req_e        req;
    logic [3:0]  slot;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [9:0]  portion;
    logic [10:0] now;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(99, 0);
      if (r < insert_wt) req = REQ_INSERT;
      else if (r < insert_wt + 20) req = REQ_UPDATE;
      else if (r < insert_wt + 20 + delete_wt) req = REQ_DELETE;
      else req = REQ_QUERY;

      if (shadow_count != 0 && $urandom_range(7, 0) != 0)
        slot = 4'($urandom_range(shadow_count - 1, 0));
      else
        slot = 4'($urandom_range(15, 0));

      pick_time(hour, minute);
      portion = ($urandom_range(15, 0) == 0) ? 10'($urandom_range(1023, 0))
                                              : 10'($urandom_range(1000, 0));

      // Current minute: in range, exactly on a stored alarm, or past the day.
      r = $urandom_range(9, 0);
      if (r == 0) now = 11'($urandom_range(2047, 0));
      else if (r == 1 && shadow_count != 0) begin
        idx = $urandom_range(shadow_count - 1, 0);
        now = 11'(shadow_alarms[idx].hour * HOUR_MINUTES + shadow_alarms[idx].minute);
      end else now = 11'($urandom_range(1439, 0));

      send_request(req, slot, hour, minute, portion, now);
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned cycles;
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    req_type_i     <= REQ_QUERY;
    slot_i         <= '0;
    alarm_hour_i   <= '0;
    alarm_minute_i <= '0;
    portion_i      <= '0;
    now_minute_i   <= '0;
    shadow_count   = 0;
    mismatch_count = 0;
    gaps_on        = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_duplicates();
    test_out_of_range_and_ties();
    test_full_table();
    test_delete_shift();
    wait_drained();

    // Ten phases of random traffic: fill-heavy, mixed and drain-heavy in turn,
    // two of them back to back, each closed by a pause until all reports are in.
    for (phase = 0; phase < 10; phase++) begin
      gaps_on = (phase != 3 && phase != 7);
      case (phase % 3)
        0:       test_random_mix(100, 55, 10);
        1:       test_random_mix(100, 30, 25);
        default: test_random_mix(100, 15, 45);
      endcase
      wait_drained();
    end

    // Wait for owed reports with a bound, then let the block settle.
    start <= 1'b0;
    for (cycles = 0; due_reports_q.size() != 0 && cycles < DRAIN_LIMIT; cycles++)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (due_reports_q.size() != 0) begin
      mismatch_count++;
      $display("%0d report(s) never arrived", due_reports_q.size());
    end

    if (mismatch_count == 0) begin
      $display("[daily_alarm_table_next_due_top] OK");
    end else begin
      $display("[daily_alarm_table_next_due_top] ERROR");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #8000000;
    $display("[daily_alarm_table_next_due_top] ERROR");
    $finish;
  end

endmodule
